// ===== src/jts_pkg.sv =====
// Shared types and constants of the JSON token scanner.
// Holds the token and error codes, the result record and the result group.
// Depends on nothing.
`timescale 1ns / 1ps

package jts_pkg;

  // Width of the offset, line and column counters (8..32); ports carry 16 bits.
  localparam int unsigned PosBits    = 16;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [PosBits-1:0] PosOne = PosBits'(1);

  typedef enum logic [3:0] {
    KindBraceOpen    = 4'd0,
    KindBraceClose   = 4'd1,
    KindComma        = 4'd2,
    KindColon        = 4'd3,
    KindBracketOpen  = 4'd4,
    KindBracketClose = 4'd5,
    KindString       = 4'd6,
    KindKeyword      = 4'd7,
    KindNumber       = 4'd8,
    KindEnd          = 4'd9,
    KindError        = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone         = 2'd0,
    ErrUnexpected   = 2'd1,
    ErrNewlineInStr = 2'd2,
    ErrUnterminated = 2'd3
  } err_e;

  typedef struct packed {
    logic [PosBits-1:0] offset;
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] column;
  } pos_t;

  typedef struct packed {
    kind_e       kind;
    err_e        code;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
  } res_t;

  // All results caused by one item, in order.
  typedef struct packed {
    res_t [MaxResults-1:0] res;
    logic [CntW-1:0]       cnt;
  } grp_t;

  // Low 16 bits of a counter, zero-extended when the counter is narrower.
  function automatic logic [15:0] out16(input logic [PosBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (v == PosMax) ? v : v + PosOne;
  endfunction

endpackage

// ===== src/jts_scan.sv =====
// Scanner state and the per-item token logic of the JSON token scanner.
// Computes every result of one item in a single pass; state moves on fire_i.
// Depends on jts_pkg.
`timescale 1ns / 1ps

module jts_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_in_i,
  input  logic          byte_valid_i,
  input  logic          doc_last_i,
  output jts_pkg::grp_t grp_o
);

  typedef enum logic [4:0] {
    ModeIdle    = 5'b00001,
    ModeString  = 5'b00010,
    ModeNumber  = 5'b00100,
    ModeKeyword = 5'b01000,
    ModeDiscard = 5'b10000
  } mode_e;

  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperE = 8'h45;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChLbrace = 8'h7B;
  localparam logic [7:0] ChRbrace = 8'h7D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChRbrack = 8'h5D;

  localparam jts_pkg::pos_t PosReset = '{
    offset: '0, line: jts_pkg::PosOne, column: jts_pkg::PosOne
  };

  mode_e                       mode_q, mode_d;
  logic                        quote_q, quote_d;
  jts_pkg::pos_t               pos_q, pos_d;
  logic [jts_pkg::PosBits-1:0] tok_start_q, tok_start_d;
  logic [jts_pkg::PosBits-1:0] tok_line_q, tok_line_d;
  logic [jts_pkg::PosBits-1:0] tok_col_q, tok_col_d;

  jts_pkg::grp_t               grp;
  logic [jts_pkg::CntW-1:0]    cnt;
  logic                        handled;
  logic [7:0]                  quote_ch;

  function automatic jts_pkg::pos_t advance(input jts_pkg::pos_t p, input logic [7:0] c);
    jts_pkg::pos_t r;
    r = p;
    if (c == ChLf) begin
      r.line   = jts_pkg::sat_inc(p.line);
      r.column = jts_pkg::PosOne;
    end else begin
      r.column = jts_pkg::sat_inc(p.column);
    end
    r.offset = jts_pkg::sat_inc(p.offset);
    return r;
  endfunction

  function automatic jts_pkg::res_t make_res(
    input jts_pkg::kind_e              kind,
    input jts_pkg::err_e               code,
    input logic [jts_pkg::PosBits-1:0] off,
    input logic [jts_pkg::PosBits-1:0] len,
    input logic [jts_pkg::PosBits-1:0] line,
    input logic [jts_pkg::PosBits-1:0] col
  );
    jts_pkg::res_t r;
    r.kind         = kind;
    r.code         = code;
    r.start_offset = jts_pkg::out16(off);
    r.text_length  = jts_pkg::out16(len);
    r.start_line   = jts_pkg::out16(line);
    r.start_column = jts_pkg::out16(col);
    return r;
  endfunction

  function automatic logic [jts_pkg::PosBits-1:0] text_len(
    input logic [jts_pkg::PosBits-1:0] off,
    input logic [jts_pkg::PosBits-1:0] start
  );
    return (off >= start) ? off - start : '0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return is_digit(c) || c == ChMinus || c == ChPlus || c == ChLowE ||
           c == ChUpperE || c == ChDot;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return c == ChLbrace || c == ChRbrace || c == ChComma || c == ChColon ||
           c == ChLbrack || c == ChRbrack;
  endfunction

  function automatic jts_pkg::kind_e punct_kind(input logic [7:0] c);
    jts_pkg::kind_e k;
    unique case (c)
      ChLbrace: k = jts_pkg::KindBraceOpen;
      ChRbrace: k = jts_pkg::KindBraceClose;
      ChComma:  k = jts_pkg::KindComma;
      ChColon:  k = jts_pkg::KindColon;
      ChLbrack: k = jts_pkg::KindBracketOpen;
      default:  k = jts_pkg::KindBracketClose;
    endcase
    return k;
  endfunction

  assign quote_ch = quote_q ? ChSquote : ChDquote;

  always_comb begin
    mode_d      = mode_q;
    quote_d     = quote_q;
    pos_d       = pos_q;
    tok_start_d = tok_start_q;
    tok_line_d  = tok_line_q;
    tok_col_d   = tok_col_q;
    grp         = '0;
    cnt         = '0;
    handled     = 1'b0;

    if (byte_valid_i) begin
      unique case (mode_q)
        ModeNumber: begin
          if (is_num_char(byte_in_i)) begin
            pos_d   = advance(pos_d, byte_in_i);
            handled = 1'b1;
          end else begin
            grp.res[cnt] = make_res(jts_pkg::KindNumber, jts_pkg::ErrNone, tok_start_d,
                                    text_len(pos_d.offset, tok_start_d), tok_line_d, tok_col_d);
            cnt    = cnt + 1'b1;
            mode_d = ModeIdle;
          end
        end
        ModeKeyword: begin
          if (byte_in_i >= ChLowA && byte_in_i <= ChLowZ) begin
            pos_d   = advance(pos_d, byte_in_i);
            handled = 1'b1;
          end else begin
            grp.res[cnt] = make_res(jts_pkg::KindKeyword, jts_pkg::ErrNone, tok_start_d,
                                    text_len(pos_d.offset, tok_start_d), tok_line_d, tok_col_d);
            cnt    = cnt + 1'b1;
            mode_d = ModeIdle;
          end
        end
        ModeString: begin
          handled = 1'b1;
          priority if (byte_in_i == ChCr || byte_in_i == ChLf) begin
            grp.res[cnt] = make_res(jts_pkg::KindError, jts_pkg::ErrNewlineInStr, pos_d.offset,
                                    '0, pos_d.line, pos_d.column);
            cnt    = cnt + 1'b1;
            mode_d = ModeDiscard;
          end else if (byte_in_i == quote_ch) begin
            grp.res[cnt] = make_res(jts_pkg::KindString, jts_pkg::ErrNone, tok_start_d,
                                    text_len(pos_d.offset, tok_start_d), tok_line_d, tok_col_d);
            cnt    = cnt + 1'b1;
            pos_d  = advance(pos_d, byte_in_i);
            mode_d = ModeIdle;
          end else begin
            pos_d = advance(pos_d, byte_in_i);
          end
        end
        ModeDiscard: handled = 1'b1;
        default:     handled = 1'b0;
      endcase

      // Idle, or a number or keyword just ended on this byte: scan it as a start byte.
      if (!handled) begin
        priority if (byte_in_i == ChCr || byte_in_i == ChLf || byte_in_i == ChTab ||
                     byte_in_i == ChSpace) begin
          pos_d = advance(pos_d, byte_in_i);
        end else if (is_punct(byte_in_i)) begin
          grp.res[cnt] = make_res(punct_kind(byte_in_i), jts_pkg::ErrNone, pos_d.offset,
                                  jts_pkg::PosOne, pos_d.line, pos_d.column);
          cnt   = cnt + 1'b1;
          pos_d = advance(pos_d, byte_in_i);
        end else if (byte_in_i == ChDquote || byte_in_i == ChSquote) begin
          // Position is that of the quote, text starts after it.
          tok_line_d  = pos_d.line;
          tok_col_d   = pos_d.column;
          quote_d     = (byte_in_i == ChSquote);
          pos_d       = advance(pos_d, byte_in_i);
          tok_start_d = pos_d.offset;
          mode_d      = ModeString;
        end else if (is_digit(byte_in_i) || byte_in_i == ChMinus || byte_in_i == ChDot) begin
          tok_start_d = pos_d.offset;
          tok_line_d  = pos_d.line;
          tok_col_d   = pos_d.column;
          pos_d       = advance(pos_d, byte_in_i);
          mode_d      = ModeNumber;
        end else if (byte_in_i == ChLowT || byte_in_i == ChLowF || byte_in_i == ChLowN) begin
          tok_start_d = pos_d.offset;
          tok_line_d  = pos_d.line;
          tok_col_d   = pos_d.column;
          pos_d       = advance(pos_d, byte_in_i);
          mode_d      = ModeKeyword;
        end else begin
          grp.res[cnt] = make_res(jts_pkg::KindError, jts_pkg::ErrUnexpected, pos_d.offset,
                                  jts_pkg::PosOne, pos_d.line, pos_d.column);
          cnt    = cnt + 1'b1;
          mode_d = ModeDiscard;
        end
      end
    end

    if (doc_last_i) begin
      priority if (mode_d == ModeNumber) begin
        grp.res[cnt] = make_res(jts_pkg::KindNumber, jts_pkg::ErrNone, tok_start_d,
                                text_len(pos_d.offset, tok_start_d), tok_line_d, tok_col_d);
        cnt = cnt + 1'b1;
      end else if (mode_d == ModeKeyword) begin
        grp.res[cnt] = make_res(jts_pkg::KindKeyword, jts_pkg::ErrNone, tok_start_d,
                                text_len(pos_d.offset, tok_start_d), tok_line_d, tok_col_d);
        cnt = cnt + 1'b1;
      end else if (mode_d == ModeString) begin
        grp.res[cnt] = make_res(jts_pkg::KindError, jts_pkg::ErrUnterminated, tok_start_d,
                                text_len(pos_d.offset, tok_start_d), tok_line_d, tok_col_d);
        cnt    = cnt + 1'b1;
        mode_d = ModeDiscard;
      end else begin
        mode_d = mode_d;
      end
      if (mode_d != ModeDiscard) begin
        grp.res[cnt] = make_res(jts_pkg::KindEnd, jts_pkg::ErrNone, pos_d.offset, '0,
                                pos_d.line, pos_d.column);
        cnt = cnt + 1'b1;
      end
      mode_d      = ModeIdle;
      quote_d     = 1'b0;
      pos_d       = PosReset;
      tok_start_d = '0;
      tok_line_d  = jts_pkg::PosOne;
      tok_col_d   = jts_pkg::PosOne;
    end

    grp.cnt = cnt;
  end

  assign grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      quote_q     <= 1'b0;
      pos_q       <= PosReset;
      tok_start_q <= '0;
      tok_line_q  <= jts_pkg::PosOne;
      tok_col_q   <= jts_pkg::PosOne;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      quote_q     <= quote_d;
      pos_q       <= pos_d;
      tok_start_q <= tok_start_d;
      tok_line_q  <= tok_line_d;
      tok_col_q   <= tok_col_d;
    end
  end

  a_pos_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q.line != '0 && pos_q.column != '0 && tok_line_q != '0 && tok_col_q != '0)
    else $error("line or column counter reached zero");

  a_start_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_start_q <= pos_q.offset)
    else $error("token start ahead of byte offset");

  a_doc_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && doc_last_i |=> mode_q == ModeIdle && pos_q == PosReset)
    else $error("scanner state not cleared after document end");

endmodule

// ===== src/jts_result_buf.sv =====
// Result register of the JSON token scanner: holds the results of one item
// and hands them out one per cycle while out_stall_i is low. Depends on jts_pkg.
`timescale 1ns / 1ps

module jts_result_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  jts_pkg::grp_t grp_i,
  output logic          room_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output jts_pkg::res_t res_o,
  output logic          run_last_o
);

  jts_pkg::grp_t            grp_q;
  logic                     valid_q;
  logic [jts_pkg::IdxW-1:0] idx_q;
  logic                     pop;
  logic                     last_res;

  assign pop      = valid_q && !out_stall_i;
  assign last_res = jts_pkg::CntW'(idx_q) == (grp_q.cnt - 1'b1);
  // Room when nothing is held, or once the final result of the held group leaves this cycle.
  assign room_o   = !valid_q || (pop && last_res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop) begin
      if (last_res) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = grp_q.res[idx_q];
  assign run_last_o  = last_res;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> jts_pkg::CntW'(idx_q) < grp_q.cnt)
    else $error("result index beyond group count");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !last_res |=> valid_q && idx_q == $past(idx_q) + 1'b1)
    else $error("result index did not step after a taken result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> room_o)
    else $error("result group loaded over pending results");

endmodule

// ===== src/json_token_scanner_core.sv =====
// Top level of the JSON token scanner: input register, scanner, result register.
// Depends on jts_pkg, jts_scan and jts_result_buf.
`timescale 1ns / 1ps

// Streaming JSON lexer, one document byte per item. An accepted item is held in
// the input register while the scanner works out all of its tokens (zero to
// three) in a single pass; those go to a result register and leave one per
// cycle while out_stall_i is low, in order, run_last_o marking the last one of
// the item. The block takes one item per cycle unless in_stall_o is high; an
// item that yields tokens holds back a later one that yields tokens until the
// last token of its run leaves the single result port, and items yielding no
// token (blanks, bytes inside a string or number) never wait on the output.
// After an error token the rest of the document is dropped and gives no END
// token; state returns to its reset value after each item with doc_last_i set.
module json_token_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  input  logic        byte_valid_i,
  input  logic        doc_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [1:0]  error_code_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] text_length_o,
  output logic [15:0] start_line_o,
  output logic [15:0] start_column_o,
  output logic        run_last_o
);

  logic          in_valid_q;
  logic [7:0]    byte_q;
  logic          byte_valid_q;
  logic          doc_last_q;
  logic          fire;
  logic          room;
  logic          in_accept;
  jts_pkg::grp_t grp;
  jts_pkg::res_t res;

  assign fire       = in_valid_q && (grp.cnt == '0 || room);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || fire) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q       <= byte_in_i;
      byte_valid_q <= byte_valid_i;
      doc_last_q   <= doc_last_i;
    end
  end

  jts_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_in_i   (byte_q),
    .byte_valid_i(byte_valid_q),
    .doc_last_i  (doc_last_q),
    .grp_o       (grp)
  );

  jts_result_buf u_result_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire && grp.cnt != '0),
    .grp_i      (grp),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res),
    .run_last_o (run_last_o)
  );

  assign token_kind_o   = res.kind;
  assign error_code_o   = res.code;
  assign start_offset_o = res.start_offset;
  assign text_length_o  = res.text_length;
  assign start_line_o   = res.start_line;
  assign start_column_o = res.start_column;

endmodule

// ===== tb/tb_json_token_scanner_core.sv =====
// Self-checking testbench for json_token_scanner_core: document bytes in, tokens out.
// A scoreboard class rebuilds the token stream from every accepted byte item.
// Depends on jts_pkg and the scanner RTL.
`timescale 1ns / 1ps

localparam logic [7:0] ChTab    = 8'h09;
localparam logic [7:0] ChLf     = 8'h0A;
localparam logic [7:0] ChCr     = 8'h0D;
localparam logic [7:0] ChSpace  = 8'h20;
localparam logic [7:0] ChDquote = 8'h22;
localparam logic [7:0] ChSquote = 8'h27;

typedef enum logic [2:0] {
  ScanIdle,
  ScanString,
  ScanNumber,
  ScanKeyword,
  ScanDiscard
} scan_e;

typedef struct packed {
  logic [3:0]  kind;
  logic [1:0]  code;
  logic [15:0] offset;
  logic [15:0] length;
  logic [15:0] line;
  logic [15:0] column;
  logic        last;
} token_t;

class token_checker;
  scan_e                       mode;
  logic                        quote_single;
  logic [jts_pkg::PosBits-1:0] pos, tok_start, tok_line, tok_col, line_no, col_no;
  token_t                      tokens_due[$];
  int                          errors;
  int                          shown;

  function new();
    errors = 0;
    shown  = 0;
    restart();
  endfunction

  function void restart();
    mode         = ScanIdle;
    quote_single = 1'b0;
    pos          = '0;
    tok_start    = '0;
    tok_line     = jts_pkg::PosOne;
    tok_col      = jts_pkg::PosOne;
    line_no      = jts_pkg::PosOne;
    col_no       = jts_pkg::PosOne;
  endfunction

  function logic [jts_pkg::PosBits-1:0] bump(input logic [jts_pkg::PosBits-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function void step_pos(input logic [7:0] c);
    if (c == ChLf) begin
      line_no = bump(line_no);
      col_no  = jts_pkg::PosOne;
    end else begin
      col_no = bump(col_no);
    end
    pos = bump(pos);
  endfunction

  function void mark();
    tok_start = pos;
    tok_line  = line_no;
    tok_col   = col_no;
  endfunction

  function void add(input jts_pkg::kind_e kind, input jts_pkg::err_e code,
                    input logic [jts_pkg::PosBits-1:0] off, len, ln, col);
    token_t t;
    t.kind   = kind;
    t.code   = code;
    t.offset = 16'(off);
    t.length = 16'(len);
    t.line   = 16'(ln);
    t.column = 16'(col);
    t.last   = 1'b0;
    tokens_due = {tokens_due, t};
  endfunction

  function void add_text(input jts_pkg::kind_e kind, input jts_pkg::err_e code);
    add(kind, code, tok_start, (pos >= tok_start) ? pos - tok_start : '0, tok_line, tok_col);
  endfunction

  function void emit_punct(input jts_pkg::kind_e kind, input logic [7:0] c);
    add(kind, jts_pkg::ErrNone, pos, jts_pkg::PosOne, line_no, col_no);
    step_pos(c);
  endfunction

  function bit num_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == "-" || c == "+" || c == "e" || c == "E" || c == ".";
  endfunction

  // Works out the tokens that one accepted item causes.
  function void note_byte(input logic [7:0] c, input logic bv, input logic last);
    int     n_old;
    bit     done;
    n_old = tokens_due.size();
    if (bv) begin
      done = 1'b0;
      case (mode)
        ScanNumber: begin
          if (num_char(c)) begin
            step_pos(c);
            done = 1'b1;
          end else begin
            add_text(jts_pkg::KindNumber, jts_pkg::ErrNone);
            mode = ScanIdle;
          end
        end
        ScanKeyword: begin
          if (c >= "a" && c <= "z") begin
            step_pos(c);
            done = 1'b1;
          end else begin
            add_text(jts_pkg::KindKeyword, jts_pkg::ErrNone);
            mode = ScanIdle;
          end
        end
        ScanString: begin
          done = 1'b1;
          if (c == ChCr || c == ChLf) begin
            add(jts_pkg::KindError, jts_pkg::ErrNewlineInStr, pos, '0, line_no, col_no);
            mode = ScanDiscard;
          end else if (c == (quote_single ? ChSquote : ChDquote)) begin
            add_text(jts_pkg::KindString, jts_pkg::ErrNone);
            step_pos(c);
            mode = ScanIdle;
          end else begin
            step_pos(c);
          end
        end
        ScanDiscard: done = 1'b1;
        default: ;
      endcase
      // a byte that closed a number or keyword is scanned again as a start byte
      if (!done) begin
        if (c == ChCr || c == ChLf || c == ChTab || c == ChSpace) begin
          step_pos(c);
        end else begin
          case (c)
            "{": emit_punct(jts_pkg::KindBraceOpen, c);
            "}": emit_punct(jts_pkg::KindBraceClose, c);
            ",": emit_punct(jts_pkg::KindComma, c);
            ":": emit_punct(jts_pkg::KindColon, c);
            "[": emit_punct(jts_pkg::KindBracketOpen, c);
            "]": emit_punct(jts_pkg::KindBracketClose, c);
            ChDquote, ChSquote: begin
              tok_line     = line_no;
              tok_col      = col_no;
              quote_single = (c == ChSquote);
              step_pos(c);
              tok_start    = pos;
              mode         = ScanString;
            end
            default: begin
              if ((c >= "0" && c <= "9") || c == "-" || c == ".") begin
                mark();
                step_pos(c);
                mode = ScanNumber;
              end else if (c == "t" || c == "f" || c == "n") begin
                mark();
                step_pos(c);
                mode = ScanKeyword;
              end else begin
                add(jts_pkg::KindError, jts_pkg::ErrUnexpected, pos, jts_pkg::PosOne,
                    line_no, col_no);
                mode = ScanDiscard;
              end
            end
          endcase
        end
      end
    end
    if (last) begin
      case (mode)
        ScanNumber:  add_text(jts_pkg::KindNumber, jts_pkg::ErrNone);
        ScanKeyword: add_text(jts_pkg::KindKeyword, jts_pkg::ErrNone);
        ScanString: begin
          add_text(jts_pkg::KindError, jts_pkg::ErrUnterminated);
          mode = ScanDiscard;
        end
        default: ;
      endcase
      if (mode != ScanDiscard) add(jts_pkg::KindEnd, jts_pkg::ErrNone, pos, '0, line_no, col_no);
      restart();
    end
    if (tokens_due.size() > n_old) begin
      tokens_due[tokens_due.size() - 1].last = 1'b1;
    end
  endfunction

  function string show(input token_t t);
    return $sformatf("kind=%0d code=%0d off=%0d len=%0d line=%0d col=%0d last=%0b",
                     t.kind, t.code, t.offset, t.length, t.line, t.column, t.last);
  endfunction

  function void check_token(input token_t got);
    token_t want;
    if (tokens_due.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: token with none expected: %s", $time, show(got));
      end
      return;
    end
    want = tokens_due.pop_front();
    if (got.kind !== want.kind || got.code !== want.code || got.offset !== want.offset ||
        got.length !== want.length || got.line !== want.line ||
        got.column !== want.column || got.last !== want.last) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: token mismatch", $time);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endfunction
endclass

module tb_json_token_scanner_core;
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  byte_in_i;
  logic        byte_valid_i;
  logic        doc_last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  token_kind_o;
  logic [1:0]  error_code_o;
  logic [15:0] start_offset_o;
  logic [15:0] text_length_o;
  logic [15:0] start_line_o;
  logic [15:0] start_column_o;
  logic        run_last_o;

  token_checker board;
  bit           no_gaps;
  bit           calm_output;
  int           n_items;
  string        punct_set = "{},:[]";
  string        num_set   = "0123456789-.+eE";
  string        kw_set    = "tfn";

  json_token_scanner_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 3);
  endfunction

  always @(posedge clk_i) begin : token_mon
    token_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {token_kind_o, error_code_o, start_offset_o, text_length_o,
             start_line_o, start_column_o, run_last_o};
      board.check_token(got);
    end
  end

  initial begin : stall_gen
    int hold;
    bit stall_now;
    out_stall_i = 1'b0;
    hold        = 0;
    stall_now   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        stall_now = ($urandom_range(0, 99) < 40);
        hold      = gap_len();
      end
      out_stall_i <= stall_now && !calm_output;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic bv, input logic last);
    int gap;
    in_valid_i   <= 1'b1;
    byte_in_i    <= b;
    byte_valid_i <= bv;
    doc_last_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_byte(b, bv, last);
    if (bv || last) n_items++;
    gap = no_gaps ? 0 : ($urandom_range(0, 1) ? 0 : gap_len());
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s, input bit end_doc);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1, end_doc && (i == s.len() - 1));
  endtask

  // Mostly well-formed token runs with random content, some noise and broken endings.
  task automatic send_doc();
    logic [7:0] doc[$];
    logic [7:0] q;
    int         ending;
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3: doc = {doc, punct_set[$urandom_range(0, 5)]};
        4, 5, 6: begin
          q = $urandom_range(0, 1) ? ChDquote : ChSquote;
          doc = {doc, q};
          repeat ($urandom_range(0, 4))
            doc = {doc, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(8'h20, 8'h7E))};
          doc = {doc, q};
        end
        7, 8, 9: begin
          doc = {doc, num_set[$urandom_range(0, 11)]};
          repeat ($urandom_range(0, 4)) doc = {doc, num_set[$urandom_range(0, 14)]};
        end
        10, 11, 12: begin
          doc = {doc, kw_set[$urandom_range(0, 2)]};
          repeat ($urandom_range(0, 4)) doc = {doc, 8'($urandom_range(8'h61, 8'h7A))};
        end
        13, 14: begin
          case ($urandom_range(0, 3))
            0: doc = {doc, ChCr};
            1: doc = {doc, ChLf};
            2: doc = {doc, ChTab};
            default: doc = {doc, ChSpace};
          endcase
        end
        default: doc = {doc, 8'($urandom_range(0, 255))};
      endcase
    end
    ending = $urandom_range(0, 9);
    if (ending == 0) begin
      // string left open at the end of the document
      doc = {doc, ChDquote};
      repeat ($urandom_range(0, 3)) doc = {doc, 8'($urandom_range(8'h41, 8'h5A))};
    end
    foreach (doc[i]) begin
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
      send_byte(doc[i], 1'b1, (ending != 1) && (i == doc.size() - 1));
    end
    if (ending == 1) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    while (board.tokens_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin : stim
    int goal;
    board        = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    byte_in_i    = '0;
    byte_valid_i = 1'b0;
    doc_last_i   = 1'b0;
    no_gaps      = 1'b0;
    calm_output  = 1'b0;
    n_items      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all punctuation, single-quoted and empty strings, keyword cut by a quote
    send_text("{'k':[t\"\",-.5]}", 1'b1);
    // number, brace and END from one item
    send_text("1}", 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_text("\t n", 1'b1);
    // newline inside a string, then the rest is dropped
    send_text("\"a\n", 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(ChDquote, 1'b1, 1'b0);
    send_byte(ChCr, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_text("\"q", 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    drain_tokens();

    goal = n_items + 60;
    while (n_items < goal) send_doc();
    drain_tokens();

    no_gaps     = 1'b1;
    calm_output = 1'b1;
    goal = n_items + 30;
    while (n_items < goal) send_doc();
    drain_tokens();
    repeat (20) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
